// ===== design/spwnl_pkg.sv =====
// Shared types and constants for the sample player with nibble loader.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
package spwnl_pkg;

   localparam int STORE_DEPTH = 32768;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = ADDR_W + 1;
   localparam int LOOP_W      = 17;
   localparam int PH_W        = LOOP_W + 16;
   localparam int QUOT_W      = 26;
   localparam int DIV_W       = 57;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam logic [3:0] SEG_IDLE  = 4'd0;
   localparam logic [3:0] SEG_PCM   = 4'd1;
   localparam logic [3:0] SEG_RATE  = 4'd2;
   localparam logic [3:0] SEG_FREQ  = 4'd3;
   localparam logic [3:0] SEG_LOOP  = 4'd4;
   localparam logic [3:0] SEG_WIDTH = 4'd5;

   localparam logic [2:0] TAG_SEGMENT = 3'd4;

   localparam logic [14:0] MAX_NARROW = 15'd127;
   localparam logic [14:0] MAX_WIDE   = 15'd32767;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [6:0]         link_word;
      logic [14:0]        start_index;
      logic signed [23:0] phase_step;
      logic [15:0]        gain;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               clipped;
   } rsp_payload_type;

   typedef struct packed {
      logic       load;
      logic       start_play;
      logic       tick_init;
      logic       rd_en;
      logic [1:0] rd_slot;
      logic       cap_en;
      logic [1:0] cap_slot;
      logic       map;
      logic       mul1;
      logic       mul2;
      logic       div_go;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

// ===== design/sample_player_with_nibble_loader_unit.sv =====
// Top level of the sample player with nibble loader.
// Depends on spwnl_pkg; instantiates spwnl_ctrl and spwnl_dpath.
`timescale 1ns / 1ps
// Usage:
// A request transfer happens at a clock edge where start is high and busy is
// low. A load word or a start request completes at that edge and leaves busy
// low, so one such request can be given every cycle.
// A tick request raises busy for four reads of the wave memory, a capture of
// the last read byte, a mapping step, two multiplier steps, a step to load the
// output scaler, the steps in which the scaler multiplies by a constant
// reciprocal, shifts and reports done, and a step to update the playhead.
// No new request transfers until busy falls again.
// The result appears in the cycle in which busy falls, on rsp_data for exactly one
// cycle with rsp_strobe high; the receiver cannot stall it.
// The interpolation enable register is written through csr_wr_en and csr_wr_data;
// the user must write it only while the block is idle, which the block does not check.
// Reset clears the loader, wave length, playhead and mode, sets the loop
// index out of range and enables interpolation. The wave memory is not
// cleared; only written entries are ever played.
module sample_player_with_nibble_loader_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  spwnl_pkg::req_payload_type req_data,
   output logic                       rsp_strobe,
   output spwnl_pkg::rsp_payload_type rsp_data,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);
   import spwnl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   spwnl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   spwnl_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== design/spwnl_div.sv =====
// Output scaler: divides the rounded product by max_code * 2^16 through a
// constant reciprocal multiply. Depends on spwnl_pkg.
`timescale 1ns / 1ps
module spwnl_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [spwnl_pkg::DIV_W-1:0]  dividend,
   input  logic [14:0]                  max_code,
   output logic                         done,
   output logic [spwnl_pkg::QUOT_W-1:0] quot
);
   import spwnl_pkg::*;

   localparam int X_W       = 30;
   localparam int R_W       = 31;
   localparam int SH_NARROW = 37;
   localparam int SH_WIDE   = 45;
   localparam logic [63:0] M_NARROW = 64'(MAX_NARROW);
   localparam logic [63:0] M_WIDE   = 64'(MAX_WIDE);
   // Any quotient above 32768 saturates, so the operand is clamped to the
   // smallest value giving 32769; that keeps the reciprocal product exact.
   localparam logic [X_W-1:0] CAP_NARROW = X_W'(64'd32769 * M_NARROW);
   localparam logic [X_W-1:0] CAP_WIDE   = X_W'(64'd32769 * M_WIDE);
   localparam logic [R_W-1:0] RCP_NARROW =
      R_W'(((64'd1 << SH_NARROW) + M_NARROW - 64'd1) / M_NARROW);
   localparam logic [R_W-1:0] RCP_WIDE =
      R_W'(((64'd1 << SH_WIDE) + M_WIDE - 64'd1) / M_WIDE);

   logic [DIV_W-17:0]    x_full;
   logic [X_W-1:0]       cap;
   logic [X_W-1:0]       x_ff, x_in;
   logic                 wide_ff, wide_in;
   logic [X_W+R_W-1:0]   prod_ff, prod_in;
   logic [QUOT_W-1:0]    q_ff, q_in;
   logic                 stage1_ff, stage2_ff, done_ff;

   always_comb begin
      // Dividing by max_code * 2^16 is dropping 16 bits, then dividing by max_code.
      wide_in = (max_code == MAX_WIDE);
      x_full  = dividend[DIV_W-1:16];
      cap     = wide_in ? CAP_WIDE : CAP_NARROW;
      if (x_full > (DIV_W-16)'(cap)) x_in = cap;
      else                           x_in = x_full[X_W-1:0];
      prod_in = (X_W+R_W)'(x_ff * (wide_ff ? RCP_WIDE : RCP_NARROW));
      if (wide_ff) q_in = QUOT_W'(prod_ff >> SH_WIDE);
      else         q_in = QUOT_W'(prod_ff >> SH_NARROW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= go;
         stage2_ff <= stage1_ff;
         done_ff   <= stage2_ff;
      end
      if (go) begin
         x_ff    <= x_in;
         wide_ff <= wide_in;
      end
      if (stage1_ff) prod_ff <= prod_in;
      if (stage2_ff) q_ff <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== design/spwnl_ctrl.sv =====
// Controller state machine: sequences loads, starts and the tick pipeline.
// Depends on spwnl_pkg for the command and status structs.
`timescale 1ns / 1ps
module spwnl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_type,
   input  spwnl_pkg::dp_status_type status,
   output spwnl_pkg::dp_cmd_type    cmd,
   output logic                     busy
);
   import spwnl_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_RDL   = 4'd2;
   localparam logic [3:0] S_MAP   = 4'd3;
   localparam logic [3:0] S_MUL1  = 4'd4;
   localparam logic [3:0] S_MUL2  = 4'd5;
   localparam logic [3:0] S_DIVGO = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] slot_ff, slot_in;

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_type)
                  REQ_LOAD:  cmd.load = 1'b1;
                  REQ_START: cmd.start_play = 1'b1;
                  REQ_TICK: begin
                     cmd.tick_init = 1'b1;
                     slot_in       = 2'd0;
                     state_in      = S_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            // Read data is registered and comes back in the cycle after the address.
            cmd.rd_en    = 1'b1;
            cmd.rd_slot  = slot_ff;
            cmd.cap_en   = (slot_ff != 2'd0);
            cmd.cap_slot = slot_ff - 2'd1;
            slot_in      = slot_ff + 2'd1;
            if (slot_ff == 2'd3) state_in = S_RDL;
         end
         S_RDL: begin
            cmd.cap_en   = 1'b1;
            cmd.cap_slot = 2'd3;
            state_in     = S_MAP;
         end
         S_MAP: begin
            cmd.map  = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            cmd.div_go = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/spwnl_dpath.sv =====
// Datapath: nibble loader, wave memory, sample fetch, interpolation, scaling
// and playhead. Depends on spwnl_pkg and instantiates spwnl_div.
`timescale 1ns / 1ps
module spwnl_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  spwnl_pkg::dp_cmd_type      cmd,
   input  spwnl_pkg::req_payload_type req_data,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   output spwnl_pkg::dp_status_type   status,
   output logic                       rsp_strobe,
   output spwnl_pkg::rsp_payload_type rsp_data
);
   import spwnl_pkg::*;

   function automatic logic signed [16:0] map8(input logic [7:0] b);
      logic signed [16:0] d;
      d = $signed({9'b0, b});
      return b[7] ? (17'sd127 - d) : d;
   endfunction

   function automatic logic signed [16:0] map16(input logic [15:0] w);
      logic signed [16:0] d;
      d = $signed({1'b0, w});
      return w[15] ? (17'sd32767 - d) : d;
   endfunction

   // Loader and wave state.
   logic [7:0]        wave_mem [STORE_DEPTH];
   logic [31:0]       shift_ff, shift_in;
   logic [3:0]        seg_ff, seg_in;
   logic [1:0]        seq_ff, seq_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              wide_ff, wide_in;
   logic [LOOP_W-1:0] loop_ff, loop_in;
   logic              mem_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_byte;
   logic              interp_ff;

   logic [3:0]  nib;
   logic [2:0]  tag;
   logic [31:0] shifted;

   assign nib     = req_data.link_word[3:0];
   assign tag     = req_data.link_word[6:4];
   assign shifted = {shift_ff[27:0], nib};

   always_comb begin
      shift_in = shift_ff;
      seg_in   = seg_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      wide_in  = wide_ff;
      loop_in  = loop_ff;
      mem_we   = 1'b0;
      wr_addr  = len_ff[ADDR_W-1:0];
      wr_byte  = shifted[7:0];
      if (cmd.load) begin
         if (tag > TAG_SEGMENT) begin
            shift_in = '0;
            seg_in   = SEG_IDLE;
            seq_in   = 2'd0;
         end else if (tag == TAG_SEGMENT) begin
            seg_in = nib;
            if (nib == SEG_PCM) begin
               len_in  = '0;
               wide_in = 1'b0;
            end
            shift_in = '0;
            seq_in   = 2'd0;
         end else if (tag[1:0] == seq_ff) begin
            shift_in = shifted;
            if (seg_ff == SEG_RATE && tag == 3'd3) seg_in = SEG_IDLE;
            if (seg_ff == SEG_FREQ && tag == 3'd3 && shifted[31:16] != 16'd0)
               seg_in = SEG_IDLE;
            if (seg_ff == SEG_LOOP && tag == 3'd3) begin
               loop_in = LOOP_W'(shifted[15:0]);
               seg_in  = SEG_IDLE;
            end
            if (seg_ff == SEG_WIDTH && tag == 3'd1) begin
               wide_in = (shifted != 32'd8);
               seg_in  = SEG_IDLE;
            end
            if (seg_ff == SEG_PCM && tag[0] && len_ff < LEN_W'(STORE_DEPTH)) begin
               mem_we   = 1'b1;
               len_in   = len_ff + 1'b1;
               shift_in = '0;
            end
            seq_in = seq_ff + 2'd1;
         end
      end
   end

   // Tick registers.
   logic [PH_W-1:0]    ph_ff;
   logic signed [23:0] step_ff;
   logic [15:0]        gain_ff;
   logic [7:0]         rd_byte_ff;
   logic [7:0]         byte_ff [4];
   logic [LEN_W-1:0]   count;
   logic [16:0]        idx;
   logic [15:0]        frac;
   logic [ADDR_W-1:0]  rd_addr;
   logic               cur_ok, nxt_ok;

   assign count = wide_ff ? (len_ff >> 1) : len_ff;
   assign idx   = ph_ff[PH_W-1:16];
   assign frac  = ph_ff[15:0];
   assign cur_ok = 18'(idx) < 18'(count);
   assign nxt_ok = (18'(idx) + 18'd1) < 18'(count);

   always_comb begin
      if (wide_ff) rd_addr = ADDR_W'({idx, 1'b0} + 18'(cmd.rd_slot));
      else         rd_addr = ADDR_W'(18'(idx) + 18'(cmd.rd_slot));
   end

   always_ff @(posedge clock) begin
      if (mem_we) wave_mem[wr_addr] <= wr_byte;
      if (cmd.rd_en) rd_byte_ff <= wave_mem[rd_addr];
   end

   logic signed [16:0] cur_ff, nxt_ff;
   logic signed [16:0] cur_map, nxt_map;
   logic signed [17:0] diff;
   logic signed [34:0] prod, v16;
   logic               neg_ff;
   logic [31:0]        mag_ff;
   logic [47:0]        num_ff;
   logic [14:0]        max_code;
   logic [DIV_W-1:0]   dividend;
   logic [QUOT_W-1:0]  quot;
   logic               div_done;

   always_comb begin
      if (wide_ff) begin
         cur_map = map16({byte_ff[0], byte_ff[1]});
         nxt_map = map16({byte_ff[2], byte_ff[3]});
      end else begin
         cur_map = map8(byte_ff[0]);
         nxt_map = map8(byte_ff[1]);
      end
      diff = 18'(nxt_ff) - 18'(cur_ff);
      prod = 35'(diff * $signed({1'b0, frac}));
      v16  = $signed({cur_ff, 16'b0}) + prod;
   end

   assign max_code = wide_ff ? MAX_WIDE : MAX_NARROW;
   // Adding half the divisor makes the truncating divide round half away from zero.
   assign dividend = DIV_W'(num_ff) + DIV_W'({max_code, 15'b0});

   spwnl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (dividend),
      .max_code (max_code),
      .done     (div_done),
      .quot     (quot)
   );

   assign status.div_done = div_done;

   // Saturation and playhead update.
   logic signed [15:0] res;
   logic               clip;
   logic signed [34:0] nh, limit;
   logic [PH_W-1:0]    ph_next;

   always_comb begin
      clip = 1'b0;
      res  = '0;
      if (neg_ff) begin
         if (quot > QUOT_W'(32768)) begin
            res  = -16'sd32768;
            clip = 1'b1;
         end else begin
            res = 16'(-$signed({1'b0, quot}));
         end
      end else begin
         if (quot > QUOT_W'(32767)) begin
            res  = 16'sd32767;
            clip = 1'b1;
         end else begin
            res = 16'(quot);
         end
      end
      nh    = $signed({2'b0, ph_ff}) + 35'(step_ff);
      limit = $signed(35'({count, 16'b0}));
      if (nh >= limit || nh < 0) ph_next = {loop_ff, 16'b0};
      else                       ph_next = PH_W'(nh);
   end

   logic              rsp_strobe_ff;
   rsp_payload_type   rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         seg_ff        <= SEG_IDLE;
         seq_ff        <= 2'd0;
         len_ff        <= '0;
         wide_ff       <= 1'b0;
         loop_ff       <= LOOP_W'(STORE_DEPTH);
         ph_ff         <= '0;
         interp_ff     <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         shift_ff      <= shift_in;
         seg_ff        <= seg_in;
         seq_ff        <= seq_in;
         len_ff        <= len_in;
         wide_ff       <= wide_in;
         loop_ff       <= loop_in;
         rsp_strobe_ff <= cmd.emit;
         if (csr_wr_en) interp_ff <= csr_wr_data;
         if (cmd.start_play) ph_ff <= {2'b0, req_data.start_index, 16'b0};
         else if (cmd.emit) ph_ff <= ph_next;
      end
      if (cmd.tick_init) begin
         step_ff <= req_data.phase_step;
         gain_ff <= req_data.gain;
      end
      if (cmd.cap_en) byte_ff[cmd.cap_slot] <= rd_byte_ff;
      if (cmd.map) begin
         cur_ff <= cur_ok ? cur_map : 17'sd0;
         // With interpolation off the slope is forced to zero.
         if (!interp_ff)  nxt_ff <= cur_ok ? cur_map : 17'sd0;
         else if (nxt_ok) nxt_ff <= nxt_map;
         else             nxt_ff <= 17'sd0;
      end
      if (cmd.mul1) begin
         neg_ff <= v16[34];
         mag_ff <= v16[34] ? 32'(-v16) : 32'(v16);
      end
      if (cmd.mul2) num_ff <= mag_ff * gain_ff;
      if (cmd.emit) begin
         rsp_data_ff.sample_out <= res;
         rsp_data_ff.clipped    <= clip;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== tb/tb_sample_player_with_nibble_loader_unit.sv =====
// Self-checking testbench for sample_player_with_nibble_loader_unit.
// Depends on spwnl_pkg and the block's RTL; a scoreboard class predicts each tick's sample.
`timescale 1ns / 1ps
module tb_sample_player_with_nibble_loader_unit;
   import spwnl_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 45;

   class playback_scoreboard;
      byte unsigned    wave_mem [STORE_DEPTH];
      int unsigned     wave_len;
      bit              wide;
      int unsigned     loop_at;
      longint          playhead;
      logic [31:0]     shifter;
      logic [3:0]      segment;
      logic [1:0]      seq;
      bit              interp;
      rsp_payload_type pending_samples [$];
      int              mismatches;
      int              ticks_checked;
      int              bytes_stored;

      function new();
         wave_len = 0;
         wide     = 0;
         loop_at  = STORE_DEPTH;
         playhead = 0;
         shifter  = '0;
         segment  = SEG_IDLE;
         seq      = '0;
         interp   = 1;
      endfunction

      function int unsigned sample_count();
         return wide ? (wave_len >> 1) : wave_len;
      endfunction

      function longint fetch(int unsigned idx);
         longint d;
         if (idx >= sample_count())
            return 0;
         if (wide) begin
            d = (longint'(wave_mem[idx * 2]) << 8) | longint'(wave_mem[idx * 2 + 1]);
            if (d > 'h7fff)
               d = 'h7fff - d;
         end else begin
            d = longint'(wave_mem[idx]);
            if (d > 'h7f)
               d = 'h7f - d;
         end
         return d;
      endfunction

      function void load_word(logic [6:0] w);
         logic [3:0] nib;
         logic [2:0] tag;
         nib = w[3:0];
         tag = w[6:4];
         if (tag > TAG_SEGMENT) begin
            shifter = '0;
            segment = SEG_IDLE;
            seq     = '0;
         end else if (tag == TAG_SEGMENT) begin
            segment = nib;
            if (nib == SEG_PCM) begin
               wave_len = 0;
               wide     = 0;
            end
            shifter = '0;
            seq     = '0;
         end else if (tag[1:0] == seq) begin
            shifter = {shifter[27:0], nib};
            if (segment == SEG_RATE && tag == 3)
               segment = SEG_IDLE;
            if (segment == SEG_FREQ && tag == 3 && shifter[31:16] != 0)
               segment = SEG_IDLE;
            if (segment == SEG_LOOP && tag == 3) begin
               loop_at = 32'(shifter[15:0]);
               segment = SEG_IDLE;
            end
            if (segment == SEG_WIDTH && tag == 1) begin
               wide    = (shifter != 32'd8);
               segment = SEG_IDLE;
            end
            if (segment == SEG_PCM && tag[0] && wave_len < STORE_DEPTH) begin
               wave_mem[wave_len] = shifter[7:0];
               wave_len++;
               bytes_stored++;
               shifter = '0;
            end
            seq = seq + 2'd1;
         end
      endfunction

      // Called at the edge where a request transfer happens.
      function void note_request(req_payload_type r);
         longint          cur, v, den, num, mag, q, res, span, nh;
         rsp_payload_type e;
         int unsigned     idx;
         case (r.req_type)
            REQ_LOAD: load_word(r.link_word);
            REQ_START: playhead = longint'(r.start_index) << 16;
            REQ_TICK: begin
               idx = 32'(playhead >> 16);
               cur = fetch(idx);
               v = cur * 65536;
               if (interp)
                  v += (fetch(idx + 1) - cur) * (playhead & 'hffff);
               den = (wide ? 32767 : 127) * longint'(65536);
               num = v * longint'(r.gain);
               mag = (num < 0) ? -num : num;
               q = (mag + den / 2) / den;
               res = (num < 0) ? -q : q;
               e.clipped = 1'b0;
               if (res > 32767) begin
                  res = 32767;
                  e.clipped = 1'b1;
               end
               if (res < -32768) begin
                  res = -32768;
                  e.clipped = 1'b1;
               end
               e.sample_out = res[15:0];
               span = longint'(sample_count()) * 65536;
               nh = playhead + longint'($signed(r.phase_step));
               if (nh >= span || nh < 0)
                  nh = longint'(loop_at) << 16;
               playhead = nh;
               pending_samples.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type e;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected sample %0d clipped %0b", $realtime, got.sample_out,
                        got.clipped);
            return;
         end
         e = pending_samples.pop_front();
         ticks_checked++;
         if (got.sample_out !== e.sample_out || got.clipped !== e.clipped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: sample expected %0d clipped %0b, got %0d clipped %0b",
                        $realtime, e.sample_out, e.clipped, got.sample_out, got.clipped);
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_data;
   logic            rsp_strobe;
   rsp_payload_type rsp_data;
   logic            csr_wr_en;
   logic            csr_wr_data;

   playback_scoreboard sb;
   int                 idle_pct;
   int                 sent;
   int                 quiet_cycles;

   sample_player_with_nibble_loader_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_payload_type random_req(logic [1:0] kind);
      req_payload_type r;
      r.req_type    = kind;
      r.link_word   = 7'($urandom);
      r.start_index = 15'($urandom);
      r.phase_step  = 24'($urandom);
      r.gain        = 16'($urandom);
      return r;
   endfunction

   // Holds the request until a transfer, then maybe leaves a gap.
   task automatic send(input req_payload_type r);
      start    <= 1;
      req_data <= r;
      do
         @(posedge clock);
      while (busy);
      sb.note_request(r);
      sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic put_word(input logic [2:0] tag, input logic [3:0] nib);
      req_payload_type r;
      r = random_req(REQ_LOAD);
      r.link_word = {tag, nib};
      send(r);
   endtask

   task automatic put_nib(input logic [3:0] nib);
      put_word({1'b0, sb.seq}, nib);
   endtask

   task automatic put_byte(input logic [7:0] b);
      put_nib(b[7:4]);
      put_nib(b[3:0]);
   endtask

   task automatic put_width(input logic [7:0] bits);
      put_word(TAG_SEGMENT, SEG_WIDTH);
      put_byte(bits);
   endtask

   task automatic put_loop(input logic [15:0] at);
      put_word(TAG_SEGMENT, SEG_LOOP);
      put_byte(at[15:8]);
      put_byte(at[7:0]);
   endtask

   task automatic put_start(input logic [14:0] at);
      req_payload_type r;
      r = random_req(REQ_START);
      r.start_index = at;
      send(r);
   endtask

   task automatic put_tick(input logic [23:0] step, input logic [15:0] level);
      req_payload_type r;
      r = random_req(REQ_TICK);
      r.phase_step = step;
      r.gain       = level;
      send(r);
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interp(input bit value);
      csr_wr_en   <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.interp = value;
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // One well-formed load and play sequence with random content, sometimes broken up.
   task automatic random_burst();
      int  nbytes;
      bit  want_wide;
      int  count;
      want_wide = 1'($urandom_range(1));
      nbytes = $urandom_range(1, 24) * (want_wide ? 2 : 1);
      put_word(TAG_SEGMENT, SEG_PCM);
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(19) == 0)
            put_word({1'b0, sb.seq + 2'($urandom_range(1, 3))}, 4'($urandom));
         put_byte(8'($urandom));
      end
      if (want_wide)
         put_width($urandom_range(1) ? 8'd16 : 8'($urandom));
      else if ($urandom_range(1))
         put_width(8'd8);
      case ($urandom_range(9))
         0: begin
            put_word(TAG_SEGMENT, SEG_RATE);
            repeat (4) put_nib(4'($urandom));
         end
         1: begin
            put_word(TAG_SEGMENT, SEG_FREQ);
            repeat (8) put_nib(4'($urandom));
         end
         2: put_word(3'($urandom_range(5, 7)), 4'($urandom));
         3: repeat ($urandom_range(1, 4)) send(random_req(REQ_LOAD));
         4: send(random_req(REQ_SPARE));
         default: ;
      endcase
      count = sb.sample_count();
      case ($urandom_range(3))
         0: put_loop(16'd0);
         1: put_loop(16'($urandom));
         default: put_loop(count > 0 ? 16'($urandom_range(count - 1)) : 16'd0);
      endcase
      if ($urandom_range(7) == 0)
         put_start(15'($urandom));
      else
         put_start(count > 0 ? 15'($urandom_range(count - 1)) : 15'd0);
      repeat ($urandom_range(2, 8)) begin
         if ($urandom_range(9) == 0)
            put_tick(24'($urandom), 16'($urandom));
         else
            put_tick(24'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536),
                     $urandom_range(3) == 0 ? 16'd32768 : 16'($urandom));
      end
   endtask

   initial begin
      sb          = new();
      reset       = 1;
      start       = 0;
      req_data    = '0;
      csr_wr_en   = 0;
      csr_wr_data = 0;
      idle_pct    = 0;
      sent        = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      write_interp(1);

      // Directed: empty wave, signed extremes of narrow and wide samples, odd requests.
      put_tick(24'h7fffff, 16'hffff);
      put_word(TAG_SEGMENT, SEG_PCM);
      put_byte(8'h7f);
      put_byte(8'h80);
      put_byte(8'hff);
      put_byte(8'h00);
      put_start(15'd0);
      put_tick(24'h00c000, 16'hffff);
      put_tick(24'h800000, 16'd32768);
      send(random_req(REQ_SPARE));
      put_tick(24'h000001, 16'd0);
      put_width(8'd16);
      put_start(15'd1);
      put_tick(24'h010000, 16'd32768);
      drain();
      write_interp(0);
      put_start(15'd0);
      put_tick(24'h7fffff, 16'hffff);
      drain();
      write_interp(1);

      // Random part: sender idles 26 percent, 57 percent, then never.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 26 : (phase == 1) ? 57 : 0;
         while (sent < 24 + 240 * (phase + 1))
            random_burst();
         // Pause until every outstanding sample has come back before the mode change.
         drain();
         write_interp(phase != 0);
      end

      // Play at both ends of a short wave, with the loop index in and out of range.
      idle_pct = 0;
      put_word(TAG_SEGMENT, SEG_PCM);
      for (int i = 0; i < 16; i++)
         put_byte(8'($urandom));
      put_loop(16'd15);
      put_start(15'd14);
      repeat (3) put_tick(24'h010000, 16'd32768);
      put_start(15'd0);
      put_tick(24'hffffff, 16'hffff);
      put_loop(16'hffff);
      put_start(15'd15);
      repeat (2) put_tick(24'h008000, 16'd32768);
      put_width(8'd16);
      put_start(15'd7);
      repeat (2) put_tick(24'h004000, 16'hffff);
      drain();
      write_interp(0);
      put_start(15'd100);
      put_tick(24'h7fffff, 16'd32768);
      drain();

      $display("Ran %0d requests: %0d tick samples checked, %0d wave bytes loaded,",
               sent, sb.ticks_checked, sb.bytes_stored);
      $display("narrow and wide waves, loop jumps at both wave ends, interpolation on and off.");
      if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
